@@ sv/rre_pkg.sv @@
// Package for the relative relocation engine: beat types, status codes,
// register indexes, permission masks and sequencer states. No dependencies.
package rre_pkg;

  localparam int MAX_SEGMENTS_DEF = 32;
  localparam int OFFSET_BITS      = 24;
  localparam int CFG_IDX_W        = 2;

  localparam logic [31:0] RELATIVE_TYPE_RST = 32'd8;

  // stored permission nibble: {loadable, read, write, execute}
  localparam logic [3:0] PERM_RW       = 4'h6;
  localparam logic [3:0] PERM_R        = 4'h4;
  localparam int         PERM_LOAD_BIT = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELATIVE_TYPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_LOW     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_BASE   = 2'd3;

  localparam logic ACT_SEGMENT = 1'b0;
  localparam logic ACT_RELOC   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNSUP   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_ISSUE,
    FSM_DRAIN
  } fsm_t;

  typedef struct packed {
    logic        action;
    logic [63:0] address;
    logic [63:0] reloc_info;
    logic [63:0] addend;
    logic [63:0] seg_file_size;
    logic [63:0] seg_mem_size;
    logic [2:0]  seg_flags;
    logic        seg_loadable;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic                   write_valid;
    logic [OFFSET_BITS-1:0] write_offset;
    logic [63:0]            write_value;
  } out_item_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] backed_size;
    logic [63:0] span;
    logic [3:0]  perm;
  } seg_entry_t;

  typedef struct packed {
    logic issue;
    logic clear;
    logic wide;
  } scan_ctl_t;

  typedef struct packed {
    logic mapped_rw;
    logic backed;
    logic mapped_r;
    logic pending;
  } scan_hits_t;

endpackage

@@ sv/rre_seg_scan.sv @@
// Segment table memory and scan pipeline: one entry read per cycle, range
// checks over two register stages, hits ORed into sticky flags. Uses rre_pkg.
module rre_seg_scan #(
  parameter int MAX_SEGMENTS = rre_pkg::MAX_SEGMENTS_DEF,
  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_idx,
  input  rre_pkg::seg_entry_t wr_entry,
  input  rre_pkg::scan_ctl_t  ctl,
  input  logic [IDX_W-1:0]    rd_idx,
  input  logic [63:0]         addr,
  input  logic [63:0]         add,
  output rre_pkg::scan_hits_t hits
);

  rre_pkg::seg_entry_t seg_mem [MAX_SEGMENTS];
  rre_pkg::seg_entry_t rd_data_r;
  logic                rd_v_r;

  // stage A: offsets from segment base
  logic        sa_v_r;
  logic [63:0] sa_d_addr_r, sa_d_add_r;
  logic        sa_addr_ge_r, sa_add_ge_r;
  logic [63:0] sa_span_r, sa_backed_r;
  logic [3:0]  sa_perm_r;

  logic mapped_rw_r, backed_r, mapped_r_r;
  logic mapped_rw_nxt, backed_nxt, mapped_r_nxt;
  logic hit_rw, hit_backed, hit_r;
  logic [3:0] word;

  // start >= 0 is given by ge; then offset d plus size must not pass bound
  function automatic logic fits(input logic ge, input logic [63:0] d,
                                input logic [63:0] bound, input logic [3:0] size);
    logic [64:0] rem;
    rem = {1'b0, bound} - {1'b0, d};
    return ge && !rem[64] && (rem[63:0] >= {60'd0, size});
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      seg_mem[wr_idx] <= wr_entry;
    end
    if (ctl.issue) begin
      rd_data_r <= seg_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    sa_d_addr_r  <= addr - rd_data_r.base;
    sa_addr_ge_r <= addr >= rd_data_r.base;
    sa_d_add_r   <= add - rd_data_r.base;
    sa_add_ge_r  <= add >= rd_data_r.base;
    sa_span_r    <= rd_data_r.span;
    sa_backed_r  <= rd_data_r.backed_size;
    sa_perm_r    <= rd_data_r.perm;
  end

  assign word = ctl.wide ? 4'd8 : 4'd4;

  always_comb begin
    hit_rw = sa_perm_r[rre_pkg::PERM_LOAD_BIT]
             && ((sa_perm_r & rre_pkg::PERM_RW) == rre_pkg::PERM_RW)
             && fits(sa_addr_ge_r, sa_d_addr_r, sa_span_r, word);
    hit_backed = sa_perm_r[rre_pkg::PERM_LOAD_BIT]
             && fits(sa_addr_ge_r, sa_d_addr_r, sa_backed_r, 4'd4);
    hit_r = sa_perm_r[rre_pkg::PERM_LOAD_BIT]
             && ((sa_perm_r & rre_pkg::PERM_R) == rre_pkg::PERM_R)
             && fits(sa_add_ge_r, sa_d_add_r, sa_span_r, 4'd1);
    if (ctl.clear) begin
      mapped_rw_nxt = 1'b0;
      backed_nxt    = 1'b0;
      mapped_r_nxt  = 1'b0;
    end else begin
      mapped_rw_nxt = mapped_rw_r | (sa_v_r & hit_rw);
      backed_nxt    = backed_r    | (sa_v_r & hit_backed);
      mapped_r_nxt  = mapped_r_r  | (sa_v_r & hit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r      <= 1'b0;
      sa_v_r      <= 1'b0;
      mapped_rw_r <= 1'b0;
      backed_r    <= 1'b0;
      mapped_r_r  <= 1'b0;
    end else begin
      rd_v_r      <= ctl.issue;
      sa_v_r      <= rd_v_r;
      mapped_rw_r <= mapped_rw_nxt;
      backed_r    <= backed_nxt;
      mapped_r_r  <= mapped_r_nxt;
    end
  end

  assign hits.mapped_rw = mapped_rw_r;
  assign hits.backed    = backed_r;
  assign hits.mapped_r  = mapped_r_r;
  assign hits.pending   = rd_v_r | sa_v_r;

endmodule

@@ sv/relative_relocation_engine.sv @@
// Relative relocation engine, top level. Sequencer, config registers and
// latched status; the segment table lives in rre_seg_scan. Uses rre_pkg.
// Segment loads and records rejected on entry give their result in the cycle
// after the accepting edge, and the next beat is taken that cycle.
// A checked record scans the table one entry a cycle through the memory read
// port, then drains the scan pipeline before its registered result is given.
// Reset (synchronous, rst_n low) empties the table and clears the status.
module relative_relocation_engine #(
  parameter int MAX_SEGMENTS = rre_pkg::MAX_SEGMENTS_DEF,
  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  rre_pkg::in_item_t                in_item,
  output logic                             out_valid,
  output rre_pkg::out_item_t               out_item,
  input  logic                             cfg_we,
  input  logic [rre_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]                      cfg_data
);

  rre_pkg::fsm_t state_r, state_nxt;

  logic        wide_r;
  logic [31:0] rel_type_r;
  logic [63:0] image_low_r, mem_base_r;

  logic [CNT_W-1:0] seg_count_r, seg_count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [63:0]      prev_r, prev_nxt;
  logic             seen_r, seen_nxt;
  rre_pkg::status_t latched_r, latched_nxt;

  logic [63:0]                     rec_addr_r, rec_rel_r;
  logic [rre_pkg::OFFSET_BITS-1:0] rec_off_r;
  logic                            rec_bad_r;

  logic               out_valid_r, out_valid_nxt;
  rre_pkg::out_item_t out_item_r, out_item_nxt;

  logic                acc, need_scan, finish, seg_wr;
  logic [3:0]          word;
  logic                misaligned, ord_bad;
  logic [64:0]         ord_diff;
  logic [63:0]         add_m, value;
  rre_pkg::seg_entry_t wr_entry;
  rre_pkg::scan_ctl_t  ctl;
  rre_pkg::scan_hits_t hits;

  assign busy = (state_r != rre_pkg::FSM_IDLE);
  assign acc  = start && !busy;

  assign word       = wide_r ? 4'd8 : 4'd4;
  assign misaligned = wide_r ? (in_item.address[2:0] != 3'd0)
                             : (in_item.address[1:0] != 2'd0);
  assign ord_diff   = {1'b0, in_item.address} - {1'b0, prev_r};
  assign ord_bad    = seen_r && (ord_diff[64] || (ord_diff[63:0] < {60'd0, word}));
  assign add_m      = wide_r ? in_item.addend : {32'd0, in_item.addend[31:0]};

  assign need_scan = acc && (in_item.action == rre_pkg::ACT_RELOC)
                     && (latched_r == rre_pkg::ST_OK)
                     && (in_item.reloc_info == {32'd0, rel_type_r});
  assign finish    = (state_r == rre_pkg::FSM_DRAIN) && !hits.pending;
  assign seg_wr    = acc && (in_item.action == rre_pkg::ACT_SEGMENT)
                     && (seg_count_r < CNT_W'(MAX_SEGMENTS));

  assign wr_entry.base        = in_item.address;
  assign wr_entry.backed_size = in_item.seg_file_size;
  assign wr_entry.span        = in_item.seg_mem_size;
  assign wr_entry.perm        = {in_item.seg_loadable, in_item.seg_flags};

  assign ctl.issue = (state_r == rre_pkg::FSM_ISSUE) && (idx_r < seg_count_r);
  assign ctl.clear = need_scan;
  assign ctl.wide  = wide_r;

  assign value = mem_base_r + rec_rel_r;

  rre_seg_scan #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (seg_wr),
    .wr_idx   (seg_count_r[IDX_W-1:0]),
    .wr_entry (wr_entry),
    .ctl      (ctl),
    .rd_idx   (idx_r[IDX_W-1:0]),
    .addr     (rec_addr_r),
    .add      (rec_rel_r + image_low_r),
    .hits     (hits)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rre_pkg::FSM_IDLE: begin
        if (need_scan) state_nxt = rre_pkg::FSM_ISSUE;
      end
      rre_pkg::FSM_ISSUE: begin
        if (idx_r >= seg_count_r) state_nxt = rre_pkg::FSM_DRAIN;
      end
      rre_pkg::FSM_DRAIN: begin
        if (!hits.pending) state_nxt = rre_pkg::FSM_IDLE;
      end
      default: state_nxt = rre_pkg::FSM_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    seg_count_nxt = seg_count_r;
    idx_nxt       = idx_r;
    prev_nxt      = prev_r;
    seen_nxt      = seen_r;
    latched_nxt   = latched_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;

    if (acc && (in_item.action == rre_pkg::ACT_SEGMENT)) begin
      if (seg_wr) begin
        seg_count_nxt = seg_count_r + CNT_W'(1);
      end else if (latched_r == rre_pkg::ST_OK) begin
        latched_nxt = rre_pkg::ST_INVALID;
      end
      out_valid_nxt = 1'b1;
    end else if (acc && !need_scan) begin
      // latched error or wrong type: answered at once
      if (latched_r == rre_pkg::ST_OK) latched_nxt = rre_pkg::ST_UNSUP;
      out_valid_nxt = 1'b1;
    end

    if (need_scan) idx_nxt = '0;
    else if (ctl.issue) idx_nxt = idx_r + CNT_W'(1);

    if (finish) begin
      out_valid_nxt = 1'b1;
      if (rec_bad_r || !hits.mapped_rw) begin
        latched_nxt = rre_pkg::ST_INVALID;
      end else begin
        prev_nxt = rec_addr_r;
        seen_nxt = 1'b1;
        if ((!wide_r && !hits.backed) || !hits.mapped_r) begin
          latched_nxt = rre_pkg::ST_INVALID;
        end else begin
          out_item_nxt.write_valid  = 1'b1;
          out_item_nxt.write_offset = rec_off_r;
          out_item_nxt.write_value  = wide_r ? value : {32'd0, value[31:0]};
        end
      end
    end
    out_item_nxt.status = latched_nxt;
  end

  always_ff @(posedge clk) begin
    if (need_scan) begin
      rec_addr_r <= in_item.address;
      rec_rel_r  <= add_m - image_low_r;
      rec_off_r  <= rre_pkg::OFFSET_BITS'(in_item.address - image_low_r);
      rec_bad_r  <= misaligned || ord_bad;
    end
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rre_pkg::FSM_IDLE;
      wide_r      <= 1'b0;
      rel_type_r  <= rre_pkg::RELATIVE_TYPE_RST;
      image_low_r <= '0;
      mem_base_r  <= '0;
      seg_count_r <= '0;
      idx_r       <= '0;
      prev_r      <= '0;
      seen_r      <= 1'b0;
      latched_r   <= rre_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_count_r <= seg_count_nxt;
      idx_r       <= idx_nxt;
      prev_r      <= prev_nxt;
      seen_r      <= seen_nxt;
      latched_r   <= latched_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          rre_pkg::CFG_WIDE_MODE:     wide_r      <= cfg_data[0];
          rre_pkg::CFG_RELATIVE_TYPE: rel_type_r  <= cfg_data[31:0];
          rre_pkg::CFG_IMAGE_LOW:     image_low_r <= cfg_data;
          rre_pkg::CFG_MEMORY_BASE:   mem_base_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ sv/rre_checker.sv @@
// Port-level checks for the relative relocation engine, bound to the top.
// Depends on rre_pkg and the top level's port names.
module rre_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input rre_pkg::in_item_t  in_item,
  input logic               out_valid,
  input rre_pkg::out_item_t out_item
);

  // segment beats answer on the next cycle
  a_seg_resp: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_item.action == rre_pkg::ACT_SEGMENT) |=> out_valid)
    else $error("segment beat without result");

  // a scan only ends by delivering its result
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("scan ended without result");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.write_valid |->
      (out_item.write_offset == '0) && (out_item.write_value == '0))
    else $error("offset or value set without write");

  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.write_valid |-> (out_item.status == rre_pkg::ST_OK))
    else $error("write reported with error status");

endmodule

bind relative_relocation_engine rre_checker u_rre_checker (.*);
